/* rtl/pmds_pkg.sv */
// Package for the pairwise Manhattan distance sum block.
// Holds parameter defaults, controller state encoding and the command/status structs.
// No dependencies.
package pmds_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int COORD_BITS_DEF = 16;
   localparam int FIELD_BITS     = 16;
   localparam int SUM_BITS       = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD_I,
      ST_LAT_I,
      ST_WALK,
      ST_DRAIN,
      ST_FIN
   } pmds_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic pair_issue;
      logic latch_i;
      logic acc_clear;
      logic load_rsp;
      logic rsp_drop;
   } pmds_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic rsp_free;
   } pmds_status_type;

endpackage

/* rtl/pmds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pmds_ctrl.sv */
// Controller for the pairwise Manhattan distance sum block: point count, pair walk
// indexes and sequencing state machine. Depends on pmds_pkg.
module pmds_ctrl #(
   parameter int MAX_POINTS = pmds_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tlast,
   output logic                          req_tready,
   input  pmds_pkg::pmds_status_type     status,
   output pmds_pkg::pmds_cmd_type        cmd,
   output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr
);
   import pmds_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CNW = $clog2(MAX_POINTS + 1);

   pmds_state_type state_ff, state_in;
   logic [CNW-1:0] count_ff, count_in;
   logic [CNW-1:0] n_ff, n_in;
   logic [CNW-1:0] i_ff, i_in;
   logic [CNW-1:0] j_ff, j_in;
   logic           ovf_ff, ovf_in;
   logic           drop_ff, drop_in;

   logic           accept;
   logic           full;
   logic [CNW-1:0] n_new;
   logic           j_end;
   logic           i_end;
   logic [CNW-1:0] rd_idx;

   assign accept = req_tvalid && (state_ff == ST_LOAD);
   assign full   = (count_ff == CNW'(MAX_POINTS));
   assign n_new  = full ? count_ff : count_ff + CNW'(1);
   assign j_end  = (j_ff == n_ff - CNW'(1));
   assign i_end  = (i_ff == n_ff - CNW'(2));

   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      ovf_in   = ovf_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (req_tlast) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  n_in     = n_new;
                  drop_in  = ovf_ff | full;
                  i_in     = '0;
               end else begin
                  count_in = n_new;
                  ovf_in   = ovf_ff | full;
               end
            end
         end
         ST_RD_I: begin
            j_in = i_ff + CNW'(1);
         end
         ST_LAT_I, ST_WALK: begin
            if (j_end) begin
               i_in = i_ff + CNW'(1);
            end else begin
               j_in = j_ff + CNW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_tlast) begin
               state_in = (n_new >= CNW'(2)) ? ST_RD_I : ST_FIN;
            end
         end
         ST_RD_I: begin
            state_in = ST_LAT_I;
         end
         ST_LAT_I, ST_WALK: begin
            if (j_end) begin
               state_in = i_end ? ST_DRAIN : ST_RD_I;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.rsp_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == ST_LOAD);
      cmd.wr_en      = accept && !full;
      cmd.rd_en      = (state_ff == ST_RD_I) || (state_ff == ST_LAT_I) ||
                       (state_ff == ST_WALK);
      cmd.pair_issue = (state_ff == ST_LAT_I) || (state_ff == ST_WALK);
      cmd.latch_i    = (state_ff == ST_LAT_I);
      cmd.acc_clear  = accept && req_tlast;
      cmd.load_rsp   = (state_ff == ST_FIN) && status.rsp_free;
      cmd.rsp_drop   = drop_ff;
      rd_idx         = (state_ff == ST_RD_I) ? i_ff : j_ff;
      wr_addr        = count_ff[AW-1:0];
      rd_addr        = rd_idx[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         n_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         ovf_ff   <= 1'b0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         ovf_ff   <= ovf_in;
         drop_ff  <= drop_in;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      cmd.pair_issue |-> (i_ff < j_ff) && (j_ff < n_ff))
      else $error("pair read out of order or beyond stored points");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(MAX_POINTS))
      else $error("point count above capacity");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("result loaded over a pending item");

   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (count_ff == '0) && !ovf_ff)
      else $error("set not cleared after last point");

endmodule

/* rtl/pmds_dp.sv */
// Datapath for the pairwise Manhattan distance sum block: point stores, distance
// pipeline, saturating accumulator and result register. Depends on pmds_pkg, pmds_ram.
module pmds_dp #(
   parameter int MAX_POINTS = pmds_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = pmds_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pmds_pkg::pmds_cmd_type              cmd,
   output pmds_pkg::pmds_status_type           status,
   input  logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
   input  logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
   input  logic [pmds_pkg::FIELD_BITS-1:0]     x_coord,
   input  logic [pmds_pkg::FIELD_BITS-1:0]     y_coord,
   output logic [pmds_pkg::SUM_BITS-1:0]       distance_sum,
   output logic                                points_dropped,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import pmds_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int SUM_W = (CW + 2 > SUM_BITS + 1) ? CW + 2 : SUM_BITS + 1;

   logic [CW+FIELD_BITS-1:0] x_ext;
   logic [CW+FIELD_BITS-1:0] y_ext;
   logic [CW-1:0]            x_rd;
   logic [CW-1:0]            y_rd;

   logic [CW-1:0]  pi_x_ff, pi_y_ff;
   logic           rd_v_ff;
   logic           d_v_ff;
   logic [CW:0]    d_ff, d_in;
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic [SUM_BITS-1:0] sum_ff;
   logic           drop_ff;
   logic           rsp_v_ff;

   logic [CW:0]    dx, dy;
   logic [CW-1:0]  adx, ady;
   logic [SUM_W-1:0] sum_wide;

   assign x_ext = {{CW{1'b0}}, x_coord};
   assign y_ext = {{CW{1'b0}}, y_coord};

   pmds_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_x_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (x_ext[CW-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   pmds_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (y_ext[CW-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   always_comb begin
      dx   = {pi_x_ff[CW-1], pi_x_ff} - {x_rd[CW-1], x_rd};
      dy   = {pi_y_ff[CW-1], pi_y_ff} - {y_rd[CW-1], y_rd};
      adx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      ady  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
      d_in = {1'b0, adx} + {1'b0, ady};
   end

   always_comb begin
      sum_wide = SUM_W'(acc_ff) + SUM_W'(d_ff);
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (d_v_ff) begin
         acc_in = (sum_wide[SUM_W-1:SUM_BITS] != '0) ? '1 : sum_wide[SUM_BITS-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_i) begin
         pi_x_ff <= x_rd;
         pi_y_ff <= y_rd;
      end
      d_ff   <= d_in;
      acc_ff <= acc_in;
      if (cmd.load_rsp) begin
         sum_ff  <= acc_ff;
         drop_ff <= cmd.rsp_drop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         d_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.pair_issue;
         d_v_ff  <= rd_v_ff;
         if (cmd.load_rsp) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   assign status.pipe_busy = rd_v_ff | d_v_ff;
   assign status.rsp_free  = !rsp_v_ff | rsp_tready;
   assign distance_sum     = sum_ff;
   assign points_dropped   = drop_ff;
   assign rsp_tvalid       = rsp_v_ff;

endmodule

/* rtl/pairwise_manhattan_distance_sum.sv */
// Top level of the pairwise Manhattan distance sum block.
// Depends on pmds_pkg, pmds_ctrl, pmds_dp (which holds two pmds_ram stores).
//
// channel  dir  tdata                               tuser            tlast
// req      in   [15:0] x_coord, [31:16] y_coord     -                last_point
// rsp      out  [31:0] distance_sum                 [0] points_dropped  -
//
// Points load at one per cycle. After the last point of a set of n stored points
// the pair walk reads the stores once per pair plus once per outer point, then drains
// the distance pipeline before the result is loaded; req_tready stays low meanwhile.
// A result waits in its output register while the next set loads; a finished walk
// holds req_tready low until an earlier result still waiting there is taken.
// Reset clears the state machine, point count and flags; store contents stay.
module pairwise_manhattan_distance_sum #(
   parameter int MAX_POINTS = pmds_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = pmds_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x_coord, [31:16] y_coord
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] distance_sum
   output logic        rsp_tuser    // [0] points_dropped
);
   import pmds_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   pmds_cmd_type    cmd;
   pmds_status_type status;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;

   pmds_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr)
   );

   pmds_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .x_coord        (req_tdata[15:0]),
      .y_coord        (req_tdata[31:16]),
      .distance_sum   (rsp_tdata),
      .points_dropped (rsp_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready)
   );

endmodule

/* sim/tb_pairwise_manhattan_distance_sum.sv */
// Testbench for pairwise_manhattan_distance_sum: streams point sets and checks each distance sum
// against a local predictor (or a directed row's fixed result), with random gaps and stalls on both sides.
// Depends on pmds_pkg and the pairwise_manhattan_distance_sum RTL.
module tb_pairwise_manhattan_distance_sum;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PTS      = pmds_pkg::MAX_POINTS_DEF;
   localparam int CW           = pmds_pkg::COORD_BITS_DEF;
   localparam int RANDOM_ITEMS = 1050;
   localparam int NUM_ROWS     = 16;
   localparam int REPORT_MAX   = 10;

   localparam logic signed [15:0] C_MIN = 16'sh8000;
   localparam logic signed [15:0] C_MAX = 16'sh7fff;

   typedef struct packed {
      logic [31:0] dist_sum;
      logic        dropped;
   } dist_result_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
      logic               fixed;
      logic [31:0]        sum;
      logic               dropped;
   } point_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] x_coord, [31:16] y_coord
   logic        req_tlast;   // last_point
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] distance_sum
   logic        rsp_tuser;   // [0] points_dropped

   logic signed [CW-1:0] x_pts [NUM_PTS];
   logic signed [CW-1:0] y_pts [NUM_PTS];
   int                   pts_held = 0;
   bit                   pts_lost = 1'b0;
   dist_result_type      sum_expect_q [$];
   int                   mismatches = 0;
   bit                   tx_burst = 1'b0;
   bit                   rx_burst = 1'b0;

   point_row_type dir_rows [NUM_ROWS] = '{
      '{16'sd0,     16'sd0,      1'b1, 1'b1, 32'd0,      1'b0},
      '{C_MIN,      C_MIN,       1'b0, 1'b0, 32'd0,      1'b0},
      '{C_MAX,      C_MAX,       1'b1, 1'b1, 32'd131070, 1'b0},
      '{C_MAX,      C_MIN,       1'b0, 1'b0, 32'd0,      1'b0},
      '{C_MIN,      C_MAX,       1'b0, 1'b0, 32'd0,      1'b0},
      '{16'sd0,     16'sd0,      1'b1, 1'b1, 32'd262140, 1'b0},
      '{16'sd5,     16'sd5,      1'b0, 1'b0, 32'd0,      1'b0},
      '{16'sd5,     16'sd5,      1'b1, 1'b1, 32'd0,      1'b0},
      '{-16'sd1,    16'sd1,      1'b0, 1'b0, 32'd0,      1'b0},
      '{16'sd100,   -16'sd200,   1'b0, 1'b0, 32'd0,      1'b0},
      '{-16'sd30000, 16'sd12345, 1'b0, 1'b0, 32'd0,      1'b0},
      '{16'sd7,     16'sd7,      1'b1, 1'b0, 32'd0,      1'b0},
      '{C_MIN,      16'sd0,      1'b0, 1'b0, 32'd0,      1'b0},
      '{C_MAX,      16'sd0,      1'b0, 1'b0, 32'd0,      1'b0},
      '{16'sd0,     C_MIN,       1'b0, 1'b0, 32'd0,      1'b0},
      '{16'sd0,     C_MAX,       1'b1, 1'b0, 32'd0,      1'b0}
   };

   pairwise_manhattan_distance_sum u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic store_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
      if (pts_held < NUM_PTS) begin
         x_pts[pts_held] = x;
         y_pts[pts_held] = y;
         pts_held++;
      end else begin
         pts_lost = 1'b1;
      end
   endtask

   task automatic close_set(output dist_result_type r);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      for (int i = 0; i < pts_held; i++) begin
         for (int j = i + 1; j < pts_held; j++) begin
            dx = longint'(x_pts[i]) - longint'(x_pts[j]);
            dy = longint'(y_pts[i]) - longint'(y_pts[j]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            acc += dx + dy;
         end
      end
      r.dist_sum = (acc > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc[31:0];
      r.dropped  = pts_lost;
      pts_held   = 0;
      pts_lost   = 1'b0;
   endtask

   task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last, input logic fixed,
                             input dist_result_type fixed_r);
      int              gap;
      dist_result_type r;
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {y, x};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      store_point(x, y);
      if (last) begin
         close_set(r);
         if (fixed) r = fixed_r;
         sum_expect_q.push_back(r);
      end
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_coord(input bit narrow);
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return narrow ? 16'(int'($urandom_range(0, 8)) - 4) : 16'($urandom);
      endcase
   endfunction

   initial begin
      int              stall;
      dist_result_type want;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
         if (sum_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: sum %0d dropped %0b", rsp_tdata, rsp_tuser);
         end else begin
            want = sum_expect_q.pop_front();
            if (rsp_tdata !== want.dist_sum || rsp_tuser !== want.dropped) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("result mismatch: expected sum %0d dropped %0b, got sum %0d dropped %0b",
                           want.dist_sum, want.dropped, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   initial begin
      int              items_sent;
      int              set_idx;
      int              set_len;
      bit              narrow;
      dist_result_type row_r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int k = 0; k < NUM_ROWS; k++) begin
         row_r.dist_sum = dir_rows[k].sum;
         row_r.dropped  = dir_rows[k].dropped;
         send_point(dir_rows[k].x, dir_rows[k].y, dir_rows[k].last, dir_rows[k].fixed, row_r);
      end

      items_sent = 0;
      set_idx    = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (set_idx == 6)
            set_len = NUM_PTS;
         else if (set_idx == 25)
            set_len = NUM_PTS + $urandom_range(1, 5);
         else if ($urandom_range(0, 7) == 0)
            set_len = $urandom_range(1, 2);
         else
            set_len = $urandom_range(3, 16);
         narrow = ($urandom_range(0, 3) == 0);
         for (int p = 0; p < set_len; p++) begin
            send_point(pick_coord(narrow), pick_coord(narrow), p == set_len - 1, 1'b0, '0);
            items_sent++;
         end
         set_idx++;
      end
      req_tvalid <= 1'b0;

      while (sum_expect_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
